@@ rtl/sacl_pkg.sv @@
// Shared types, constants and helpers for the set-associative LRU lookup block.
package sacl_pkg;

	localparam int MAX_WAYS  = 8;
	localparam int MAX_SETS  = 64;
	localparam int ADDR_BITS = 16;

	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SET_MAX = $clog2(MAX_SETS);
	localparam int TAG_W   = ADDR_BITS;
	localparam int AGE_W   = 16;
	localparam int CNT_W   = 32;

	// Configuration register widths
	localparam int OFS_CFG_W  = 4;
	localparam int SETB_CFG_W = 3;
	localparam int WAYS_CFG_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Output stream: hit, way_used, set_index, hit_total, miss_total
	localparam int RES_W       = 1 + 3 + 6 + CNT_W + CNT_W;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int IN_TDATA_W  = ((ADDR_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_SET_BITS    = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_idx_t;

	// Back-end sequencer states
	typedef enum logic {
		BK_READ,
		BK_EVAL
	} back_state_t;

	// Classified request passed from front to back
	typedef struct packed {
		logic [SET_W-1:0] set;
		logic [TAG_W-1:0] tag;
	} req_t;

	// One set: tags and ages of every way
	typedef struct packed {
		logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
		logic [MAX_WAYS-1:0][AGE_W-1:0] age;
	} row_t;

	// Result carried by the output register
	typedef struct packed {
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] hit_total;
		logic [5:0]       set_index;
		logic [2:0]       way_used;
		logic             hit;
	} res_t;

	// Age a valid way by one, holding at the top value
	function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
		logic [AGE_W-1:0] r;
		r = a;
		if (a != '0 && a != '1) begin
			r = a + AGE_W'(1);
		end
		return r;
	endfunction

endpackage

@@ rtl/sacl_front.sv @@
// Front end: split each address into set index and tag.
module sacl_front (
	input  logic [sacl_pkg::ADDR_BITS-1:0]  address,
	input  logic [sacl_pkg::OFS_CFG_W-1:0]  offset_bits,
	input  logic [sacl_pkg::SETB_CFG_W-1:0] set_bits,
	output sacl_pkg::req_t                  req
);

	localparam int SUM_W = sacl_pkg::OFS_CFG_W + 1;

	logic [sacl_pkg::SETB_CFG_W-1:0] sb;
	logic [sacl_pkg::ADDR_BITS-1:0]  above;
	logic [sacl_pkg::SET_W:0]        set_mask;
	logic [SUM_W-1:0]                tag_shift;

	// Clamp set bits to the sets that exist
	always_comb begin
		sb = set_bits;
		if (32'(set_bits) > sacl_pkg::SET_MAX) begin
			sb = sacl_pkg::SETB_CFG_W'(sacl_pkg::SET_MAX);
		end
	end

	// Drop the line offset, mask the set, shift out the tag
	always_comb begin
		above     = address >> offset_bits;
		set_mask  = ((sacl_pkg::SET_W+1)'(1) << sb) - (sacl_pkg::SET_W+1)'(1);
		tag_shift = SUM_W'(offset_bits) + SUM_W'(sb);
		req.set   = above[sacl_pkg::SET_W-1:0] & set_mask[sacl_pkg::SET_W-1:0];
		req.tag   = sacl_pkg::TAG_W'(address >> tag_shift);
	end

endmodule

@@ rtl/sacl_queue.sv @@
// Short request queue between the front end and the back end.
module sacl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sacl_pkg::req_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output sacl_pkg::req_t item
);

	sacl_pkg::req_t                 entry_q [sacl_pkg::QUEUE_DEPTH];
	logic [sacl_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sacl_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sacl_pkg::QCNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == sacl_pkg::QCNT_W'(sacl_pkg::QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign item  = entry_q[rd_ptr_q];

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sacl_pkg::QPTR_W'(sacl_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + sacl_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sacl_pkg::QPTR_W'(sacl_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + sacl_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + sacl_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - sacl_pkg::QCNT_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= sacl_pkg::QUEUE_DEPTH)
		else $error("queue fill level out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");
`endif

endmodule

@@ rtl/sacl_back.sv @@
// Back end: set read, tag compare, LRU update, write back and result register.
module sacl_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sacl_pkg::WAYS_CFG_W-1:0] ways_in_use,
	input  logic                            q_valid,
	input  sacl_pkg::req_t                  q_item,
	output logic                            q_pop,
	output logic                            res_valid,
	input  logic                            res_ready,
	output sacl_pkg::res_t                  res
);

	sacl_pkg::back_state_t            state_q;
	sacl_pkg::back_state_t            state_nxt;

	sacl_pkg::row_t                   mem_q [sacl_pkg::MAX_SETS];
	logic [sacl_pkg::MAX_SETS-1:0]    row_vld_q;

	sacl_pkg::row_t                   rd_row_s2;
	logic                             rd_vld_s2;
	sacl_pkg::req_t                   item_s2;

	logic [sacl_pkg::CNT_W-1:0]       hit_cnt_q;
	logic [sacl_pkg::CNT_W-1:0]       miss_cnt_q;
	logic [sacl_pkg::CNT_W-1:0]       hit_cnt_nxt;
	logic [sacl_pkg::CNT_W-1:0]       miss_cnt_nxt;

	logic                             out_valid_q;
	sacl_pkg::res_t                   out_q;

	logic [sacl_pkg::WAYS_CFG_W-1:0]  nw;
	logic                             out_free;
	logic                             wr_en;
	sacl_pkg::row_t                   row;
	sacl_pkg::row_t                   new_row;
	logic [sacl_pkg::MAX_WAYS-1:0]    in_use;
	logic                             hit;
	logic [sacl_pkg::WAY_W-1:0]       hit_way;
	logic                             free_ok;
	logic [sacl_pkg::WAY_W-1:0]       free_way;
	logic [sacl_pkg::WAY_W-1:0]       old_way;
	logic [sacl_pkg::AGE_W-1:0]       old_age;
	logic [sacl_pkg::WAY_W-1:0]       victim;

	assign out_free  = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Clamp the way count to one..MAX_WAYS
	always_comb begin
		nw = ways_in_use;
		if (ways_in_use == '0) begin
			nw = sacl_pkg::WAYS_CFG_W'(1);
		end else if (32'(ways_in_use) > sacl_pkg::MAX_WAYS) begin
			nw = sacl_pkg::WAYS_CFG_W'(sacl_pkg::MAX_WAYS);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sacl_pkg::BK_READ: begin
				if (q_valid) begin
					state_nxt = sacl_pkg::BK_EVAL;
				end
			end
			sacl_pkg::BK_EVAL: begin
				if (out_free) begin
					state_nxt = sacl_pkg::BK_READ;
				end
			end
			default: state_nxt = sacl_pkg::BK_READ;
		endcase
	end

	// State outputs
	always_comb begin
		q_pop = 1'b0;
		wr_en = 1'b0;
		unique case (state_q)
			sacl_pkg::BK_READ: q_pop = q_valid;
			sacl_pkg::BK_EVAL: wr_en = out_free;
			default: begin
				q_pop = 1'b0;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacl_pkg::BK_READ;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Read the set row; unwritten sets read as all zero
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_row_s2 <= mem_q[q_item.set];
			item_s2   <= q_item;
		end
		if (wr_en) begin
			mem_q[item_s2.set] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s2 <= 1'b0;
		end else begin
			if (q_pop) begin
				rd_vld_s2 <= row_vld_q[q_item.set];
			end
			if (wr_en) begin
				row_vld_q[item_s2.set] <= 1'b1;
			end
		end
	end

	// Compare the ways in use, pick hit, free or oldest way
	always_comb begin
		row      = rd_vld_s2 ? rd_row_s2 : '0;
		hit      = 1'b0;
		hit_way  = '0;
		free_ok  = 1'b0;
		free_way = '0;
		old_way  = '0;
		old_age  = '0;
		for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
			in_use[w] = (sacl_pkg::WAYS_CFG_W'(w) < nw);
			if (in_use[w] && row.age[w] != '0 && row.tag[w] == item_s2.tag && !hit) begin
				hit     = 1'b1;
				hit_way = sacl_pkg::WAY_W'(w);
			end
			if (in_use[w] && row.age[w] == '0) begin
				free_ok  = 1'b1;
				free_way = sacl_pkg::WAY_W'(w);
			end
			if (in_use[w] && row.age[w] > old_age) begin
				old_age = row.age[w];
				old_way = sacl_pkg::WAY_W'(w);
			end
		end
		victim = hit ? hit_way : (free_ok ? free_way : old_way);
	end

	// Age valid ways, refresh the chosen way, load the tag on a miss
	always_comb begin
		new_row = row;
		for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
			if (in_use[w]) begin
				new_row.age[w] = sacl_pkg::age_up(row.age[w]);
				if (sacl_pkg::WAY_W'(w) == victim) begin
					new_row.age[w] = sacl_pkg::AGE_W'(1);
					if (!hit) begin
						new_row.tag[w] = item_s2.tag;
					end
				end
			end
		end
	end

	// Saturating hit and miss counts
	always_comb begin
		hit_cnt_nxt  = hit_cnt_q;
		miss_cnt_nxt = miss_cnt_q;
		if (hit && hit_cnt_q != '1) begin
			hit_cnt_nxt = hit_cnt_q + sacl_pkg::CNT_W'(1);
		end
		if (!hit && miss_cnt_q != '1) begin
			miss_cnt_nxt = miss_cnt_q + sacl_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				hit_cnt_q   <= hit_cnt_nxt;
				miss_cnt_q  <= miss_cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_q.hit        <= hit;
			out_q.way_used   <= 3'(victim);
			out_q.set_index  <= 6'(item_s2.set);
			out_q.hit_total  <= hit_cnt_nxt;
			out_q.miss_total <= miss_cnt_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_res_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sacl_pkg::BK_EVAL))
		else $error("result appeared without an evaluation cycle");
	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hit_cnt_q >= $past(hit_cnt_q)) && (miss_cnt_q >= $past(miss_cnt_q)))
		else $error("hit or miss count went down");
	a_one_count_per_request: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (hit_cnt_q != $past(hit_cnt_q)) || (miss_cnt_q != $past(miss_cnt_q)) ||
			($past(hit_cnt_q) == '1) || ($past(miss_cnt_q) == '1))
		else $error("request finished without counting");
	a_no_pop_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sacl_pkg::BK_EVAL) |-> !q_pop)
		else $error("queue popped while a request is in evaluation");
`endif

endmodule

@@ rtl/set_assoc_cache_lru_lookup.sv @@
// Top level of the set-associative cache lookup with LRU replacement.
//
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   tdata[15:0] address
//  m_axis   out  m_axis_tvalid/tready   tdata: hit, way_used, set_index, hit_total, miss_total
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// In the back end, BK_READ reads the set row from the single-ported row memory;
// BK_EVAL compares the ways in use, writes the row back and sets m_axis_tvalid,
// waiting while m_axis still holds the result. Requests are read one at a time.
// Reset clears one valid bit per set at once, so no clearing pass is needed.
// A two-entry queue keeps s_axis accepting while the result register waits on m_axis, until it fills.
module set_assoc_cache_lru_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [sacl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] address
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] hit, [3:1] way_used, [9:4] set_index, [41:10] hit_total,
	// [73:42] miss_total, [79:74] zero
	output logic [sacl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [sacl_pkg::OFS_CFG_W-1:0]  offset_bits_q;
	logic [sacl_pkg::SETB_CFG_W-1:0] set_bits_q;
	logic [sacl_pkg::WAYS_CFG_W-1:0] ways_in_use_q;

	sacl_pkg::req_t front_req;
	sacl_pkg::req_t q_item;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	logic           push;
	sacl_pkg::res_t res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= sacl_pkg::OFS_CFG_W'(4);
			set_bits_q    <= sacl_pkg::SETB_CFG_W'(3);
			ways_in_use_q <= sacl_pkg::WAYS_CFG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sacl_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data[sacl_pkg::OFS_CFG_W-1:0];
				sacl_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data[sacl_pkg::SETB_CFG_W-1:0];
				sacl_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[sacl_pkg::WAYS_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sacl_front u_front (
		.address     (s_axis_tdata[sacl_pkg::ADDR_BITS-1:0]),
		.offset_bits (offset_bits_q),
		.set_bits    (set_bits_q),
		.req         (front_req)
	);

	sacl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_req),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.item      (q_item)
	);

	sacl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ways_in_use (ways_in_use_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res         (res)
	);

	// Pack the result, first field lowest
	assign m_axis_tdata = {(sacl_pkg::OUT_TDATA_W - sacl_pkg::RES_W)'(0), res};

endmodule
